// ----- src/clss_pkg.sv -----
package clss_pkg;

    localparam int KEY_W     = 8;
    localparam int TIMEOUT_W = 20;
    localparam int FLASH_W   = 3;
    localparam int MS_W      = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    localparam logic [MS_W-1:0] FAST_ON_MS  = 9'd80;
    localparam logic [MS_W-1:0] FAST_OFF_MS = 9'd60;
    localparam logic [MS_W-1:0] SLOW_ON_MS  = 9'd300;
    localparam logic [MS_W-1:0] SLOW_OFF_MS = 9'd200;

    localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT_MS = 20'(5 * 60 * 1000);
    localparam logic [KEY_W-1:0]     DEFAULT_LEFT_A     = 8'd20;
    localparam logic [KEY_W-1:0]     DEFAULT_LEFT_B     = 8'd21;
    localparam logic [KEY_W-1:0]     DEFAULT_RIGHT_A    = 8'd30;
    localparam logic [KEY_W-1:0]     DEFAULT_RIGHT_B    = 8'd31;
    localparam logic [FLASH_W-1:0]   DEFAULT_FLASH      = 3'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_KEY_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_KEY_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_KEY_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_KEY_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_TMO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_CNT   = 3'd5;

    localparam logic [1:0] REASON_NONE  = 2'd0;
    localparam logic [1:0] REASON_CHORD = 2'd1;
    localparam logic [1:0] REASON_LINK  = 2'd2;

    typedef enum logic [1:0] {
        CMD_KEY  = 2'd0,
        CMD_LINK = 2'd1,
        CMD_TICK = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2,
        PH_DONE = 2'd3
    } t_blink_phase;

    typedef struct packed {
        logic [KEY_W-1:0]     left_key_a;
        logic [KEY_W-1:0]     left_key_b;
        logic [KEY_W-1:0]     right_key_a;
        logic [KEY_W-1:0]     right_key_b;
        logic [TIMEOUT_W-1:0] link_timeout_ms;
        logic [FLASH_W-1:0]   flash_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0] sleep_reason;
        logic       power_off;
        logic       led_on;
    } t_result;

endpackage

// ----- src/clss_cfg_regs.sv -----
module clss_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [clss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [clss_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output clss_pkg::t_cfg                o_cfg
);

    clss_pkg::t_cfg r_cfg;
    clss_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                clss_pkg::CFG_LEFT_KEY_A:  n_cfg.left_key_a  = i_cfg_data[7:0];
                clss_pkg::CFG_LEFT_KEY_B:  n_cfg.left_key_b  = i_cfg_data[7:0];
                clss_pkg::CFG_RIGHT_KEY_A: n_cfg.right_key_a = i_cfg_data[7:0];
                clss_pkg::CFG_RIGHT_KEY_B: n_cfg.right_key_b = i_cfg_data[7:0];
                clss_pkg::CFG_LINK_TMO:    n_cfg.link_timeout_ms = i_cfg_data;
                clss_pkg::CFG_FLASH_CNT:   n_cfg.flash_count = i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_key_a      <= clss_pkg::DEFAULT_LEFT_A;
            r_cfg.left_key_b      <= clss_pkg::DEFAULT_LEFT_B;
            r_cfg.right_key_a     <= clss_pkg::DEFAULT_RIGHT_A;
            r_cfg.right_key_b     <= clss_pkg::DEFAULT_RIGHT_B;
            r_cfg.link_timeout_ms <= clss_pkg::DEFAULT_TIMEOUT_MS;
            r_cfg.flash_count     <= clss_pkg::DEFAULT_FLASH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- src/clss_core.sv -----
module clss_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [1:0]                    i_cmd,
    input  logic [clss_pkg::KEY_W-1:0]    i_key_position,
    input  logic                          i_key_pressed,
    input  logic                          i_link_up,
    input  clss_pkg::t_cfg                i_cfg,
    output clss_pkg::t_result             o_res
);

    logic [3:0]                       r_key_down,  n_key_down;
    logic [1:0]                       r_armed,     n_armed;
    logic                             r_pending,   n_pending;
    logic [clss_pkg::TIMEOUT_W-1:0]   r_tmo_left,  n_tmo_left;
    logic                             r_sleep,     n_sleep;
    clss_pkg::t_blink_phase           r_phase,     n_phase;
    logic [clss_pkg::FLASH_W-1:0]     r_blinks,    n_blinks;
    logic [clss_pkg::MS_W-1:0]        r_ms_left,   n_ms_left;
    logic                             r_slow,      n_slow;

    logic fire;
    logic expire;
    logic tick;

    // Chord, link and timeout tracking
    always_comb begin
        logic hit;
        logic ka;
        logic kb;
        n_key_down = r_key_down;
        n_armed    = r_armed;
        n_pending  = r_pending;
        n_tmo_left = r_tmo_left;
        fire       = 1'b0;
        expire     = 1'b0;
        tick       = 1'b0;
        hit        = 1'b1;
        ka         = 1'b0;
        kb         = 1'b0;
        case (clss_pkg::t_cmd'(i_cmd))
            clss_pkg::CMD_KEY: begin
                // first matching register wins when positions are shared
                if (i_key_position == i_cfg.left_key_a)       n_key_down[0] = i_key_pressed;
                else if (i_key_position == i_cfg.left_key_b)  n_key_down[1] = i_key_pressed;
                else if (i_key_position == i_cfg.right_key_a) n_key_down[2] = i_key_pressed;
                else if (i_key_position == i_cfg.right_key_b) n_key_down[3] = i_key_pressed;
                else hit = 1'b0;
                if (hit) begin
                    for (int c = 0; c < 2; c++) begin
                        ka = n_key_down[2*c];
                        kb = n_key_down[2*c+1];
                        if (ka && kb) n_armed[c] = 1'b1;
                        if (n_armed[c] && !ka && !kb) begin
                            n_armed[c] = 1'b0;
                            fire       = 1'b1;
                        end
                    end
                end
            end
            clss_pkg::CMD_LINK: begin
                if (i_link_up) begin
                    n_pending  = 1'b0;
                    n_tmo_left = '0;
                end else if (!r_pending) begin
                    n_pending  = 1'b1;
                    n_tmo_left = i_cfg.link_timeout_ms;
                end
            end
            clss_pkg::CMD_TICK: begin
                tick = 1'b1;
                if (r_pending) begin
                    // zero load acts like one: expire on the next tick
                    if (r_tmo_left <= clss_pkg::TIMEOUT_W'(1)) begin
                        n_pending  = 1'b0;
                        n_tmo_left = '0;
                        expire     = 1'b1;
                    end else begin
                        n_tmo_left = r_tmo_left - clss_pkg::TIMEOUT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Blink sequencer next state
    always_comb begin
        n_sleep   = r_sleep;
        n_slow    = r_slow;
        n_phase   = r_phase;
        n_blinks  = r_blinks;
        n_ms_left = r_ms_left;
        if ((fire || expire) && !r_sleep) begin
            n_sleep  = 1'b1;
            n_slow   = expire;
            n_blinks = i_cfg.flash_count;
            if (i_cfg.flash_count == '0) begin
                n_phase   = clss_pkg::PH_DONE;
                n_ms_left = '0;
            end else begin
                n_phase   = clss_pkg::PH_ON;
                n_ms_left = expire ? clss_pkg::SLOW_ON_MS : clss_pkg::FAST_ON_MS;
            end
        end else if (tick) begin
            case (r_phase)
                clss_pkg::PH_ON: begin
                    if (r_ms_left > clss_pkg::MS_W'(1)) begin
                        n_ms_left = r_ms_left - clss_pkg::MS_W'(1);
                    end else begin
                        n_phase   = clss_pkg::PH_OFF;
                        n_ms_left = r_slow ? clss_pkg::SLOW_OFF_MS : clss_pkg::FAST_OFF_MS;
                    end
                end
                clss_pkg::PH_OFF: begin
                    if (r_ms_left > clss_pkg::MS_W'(1)) begin
                        n_ms_left = r_ms_left - clss_pkg::MS_W'(1);
                    end else begin
                        n_blinks = r_blinks - clss_pkg::FLASH_W'(1);
                        if (n_blinks == '0) begin
                            n_phase   = clss_pkg::PH_DONE;
                            n_ms_left = '0;
                        end else begin
                            n_phase   = clss_pkg::PH_ON;
                            n_ms_left = r_slow ? clss_pkg::SLOW_ON_MS : clss_pkg::FAST_ON_MS;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result levels after this item
    always_comb begin
        o_res.led_on    = (n_phase == clss_pkg::PH_ON);
        o_res.power_off = (n_phase == clss_pkg::PH_DONE);
        if (!n_sleep)    o_res.sleep_reason = clss_pkg::REASON_NONE;
        else if (n_slow) o_res.sleep_reason = clss_pkg::REASON_LINK;
        else             o_res.sleep_reason = clss_pkg::REASON_CHORD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_down <= '0;
            r_armed    <= '0;
            r_pending  <= 1'b0;
            r_tmo_left <= '0;
            r_sleep    <= 1'b0;
            r_phase    <= clss_pkg::PH_IDLE;
            r_blinks   <= '0;
            r_ms_left  <= '0;
            r_slow     <= 1'b0;
        end else if (i_step) begin
            r_key_down <= n_key_down;
            r_armed    <= n_armed;
            r_pending  <= n_pending;
            r_tmo_left <= n_tmo_left;
            r_sleep    <= n_sleep;
            r_phase    <= n_phase;
            r_blinks   <= n_blinks;
            r_ms_left  <= n_ms_left;
            r_slow     <= n_slow;
        end
    end

endmodule

// ----- src/chord_and_link_timeout_sleep_sequencer_top.sv -----
// Channel   | Dir | Handshake                    | Payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser cmd, tdata key/link fields
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata led_on, power_off, sleep_reason
// cfg       | in  | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One item per clock sustained while the result is not stalled.
// An input register feeds the state update logic, which loads the result register.
// Reset is synchronous, active low; all chord, timeout and blink state clears to zero.
// A stalled result holds the pipeline; the input register takes one more item while
// the result waits only if it is empty. The config port is always ready.
module chord_and_link_timeout_sleep_sequencer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // [7:0] key_position, [8] key_pressed, [9] link_up
    input  logic [1:0]                     s_axis_tuser,  // [1:0] cmd
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [0] led_on, [1] power_off, [3:2] sleep_reason
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [clss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [clss_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    logic                         r_in_valid;
    logic [1:0]                   r_in_cmd;
    logic [clss_pkg::KEY_W-1:0]   r_in_pos;
    logic                         r_in_pressed;
    logic                         r_in_link_up;
    logic                         r_out_valid;
    clss_pkg::t_result            r_out;

    clss_pkg::t_cfg               cfg;
    clss_pkg::t_result            res;
    logic                         advance;
    logic                         step;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.sleep_reason, r_out.power_off, r_out.led_on};

    clss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    clss_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_cmd          (r_in_cmd),
        .i_key_position (r_in_pos),
        .i_key_pressed  (r_in_pressed),
        .i_link_up      (r_in_link_up),
        .i_cfg          (cfg),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd     <= s_axis_tuser;
            r_in_pos     <= s_axis_tdata[7:0];
            r_in_pressed <= s_axis_tdata[8];
            r_in_link_up <= s_axis_tdata[9];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

endmodule

// ----- src/clss_checker.sv -----
module clss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic r_seen_off;
    logic r_seen_reason;
    logic [1:0] r_reason;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_off    <= 1'b0;
            r_seen_reason <= 1'b0;
            r_reason      <= clss_pkg::REASON_NONE;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (m_axis_tdata[1]) r_seen_off <= 1'b1;
            if (m_axis_tdata[3:2] != clss_pkg::REASON_NONE) begin
                r_seen_reason <= 1'b1;
                r_reason      <= m_axis_tdata[3:2];
            end
        end
    end

    // power-off is sticky once reported
    a_off_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_seen_off) |-> m_axis_tdata[1])
        else $error("power_off dropped after being reported");

    // sleep reason never changes once set
    a_reason_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_seen_reason) |-> (m_axis_tdata[3:2] == r_reason))
        else $error("sleep_reason changed after latch");

    // LED or power-off only with a sleep reason, and never both at once
    a_reason_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[1]))
            |-> ((m_axis_tdata[3:2] == clss_pkg::REASON_CHORD ||
                  m_axis_tdata[3:2] == clss_pkg::REASON_LINK) &&
                 !(m_axis_tdata[0] && m_axis_tdata[1])))
        else $error("LED or power-off without a sleep reason");

    a_out_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

bind chord_and_link_timeout_sleep_sequencer_top clss_checker u_clss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
